/* rtl/ptd_pkg.sv */
// Package for the periodic task dispatcher: sizes, operation and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package ptd_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int TICK_W    = 32;
    localparam int MODE_W    = 3;

    // operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ENABLE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DISABLE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RUN     = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PARAM = 2'd1,
        ST_LINKED    = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    latch;      // capture the input word
        logic    add_tail;   // hook new slot behind current tail
        logic    add_link;   // fill slot entry and link it in
        logic    walk_init;  // start predecessor search at head
        logic    walk_step;  // advance predecessor search
        logic    unlink;     // splice slot out of the ring
        logic    enable;     // restamp and set enabled mark
        logic    dis_slot;   // clear enabled mark
        logic    scan_init;  // start scan at round-robin pointer
        logic    scan_step;  // advance scan to successor
        logic    dispatch;   // restamp current slot, move pointer past it
        logic    out_load;   // load the result register
        t_status res_status;
        logic    res_disp;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              period_zero;
        logic              slot_linked;
        logic              ring_empty;
        logic              any_linked;
        logic              cur_hit;    // walk pointer sits on the named slot
        logic              walk_last;  // step counter at its last value
        logic              due;        // current slot is due for dispatch
        logic              scan_last;  // successor closes the ring or count ran out
        logic              out_free;   // result register can take a word
    } t_dp_stat;

endpackage

/* rtl/ptd_dp.sv */
// Datapath of the periodic task dispatcher: slot tables, ring pointers,
// walk/scan cursor and the result register. Depends on ptd_pkg.
module ptd_dp import ptd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SLOT_W-1:0] i_task_slot,
    input  logic [TICK_W-1:0] i_task_period,
    input  logic [TICK_W-1:0] i_now_tick,
    input  logic              i_stall,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic              o_dispatched,
    output logic [SLOT_W-1:0] o_dispatched_task
);

    // slot tables
    logic [SLOT_W-1:0] r_next   [MAX_TASKS];
    logic [TICK_W-1:0] r_period [MAX_TASKS];
    logic [TICK_W-1:0] r_last   [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_linked;
    logic [MAX_TASKS-1:0] r_en;

    // ring pointers
    logic [SLOT_W-1:0] r_head, r_tail, r_ptr;
    logic              r_empty;

    // latched input word
    logic [MODE_W-1:0] r_mode;
    logic [SLOT_W-1:0] r_slot;
    logic [TICK_W-1:0] r_period_in;
    logic [TICK_W-1:0] r_now;

    // cursor
    logic [SLOT_W-1:0] r_cur, r_prev, r_cnt;

    // result register
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic              r_out_disp;
    logic [SLOT_W-1:0] r_out_task;

    logic [SLOT_W-1:0] rd_next;
    logic [TICK_W-1:0] rd_period, rd_last, elapsed;
    logic              out_take;

    // single read port at the cursor
    assign rd_next   = r_next[r_cur];
    assign rd_period = r_period[r_cur];
    assign rd_last   = r_last[r_cur];
    assign elapsed   = r_now - rd_last;
    assign out_take  = r_out_valid && !i_stall;

    // status to the controller
    always_comb begin
        o_stat.mode        = r_mode;
        o_stat.period_zero = (r_period_in == '0);
        o_stat.slot_linked = r_linked[r_slot];
        o_stat.ring_empty  = r_empty;
        o_stat.any_linked  = |r_linked;
        o_stat.cur_hit     = (r_cur == r_slot);
        o_stat.walk_last   = (r_cnt == SLOT_W'(MAX_TASKS - 1));
        o_stat.due         = r_linked[r_cur] && r_en[r_cur] && (elapsed >= rd_period);
        o_stat.scan_last   = (rd_next == r_ptr) || (r_cnt == SLOT_W'(MAX_TASKS - 1));
        o_stat.out_free    = !r_out_valid || !i_stall;
    end

    // control state: marks, pointers, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linked    <= '0;
            r_en        <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_ptr       <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // a new word may replace the one taken in the same cycle
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.add_link) begin
                r_linked[r_slot] <= 1'b1;
                r_en[r_slot]     <= 1'b1;
                r_tail           <= r_slot;
                if (r_empty) begin
                    r_head  <= r_slot;
                    r_ptr   <= r_slot;
                    r_empty <= 1'b0;
                end
            end
            if (i_cmd.unlink) begin
                r_linked[r_slot] <= 1'b0;
                r_en[r_slot]     <= 1'b0;
                if (rd_next == r_slot) begin
                    // last slot leaves
                    r_empty <= 1'b1;
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_ptr   <= '0;
                end else begin
                    if (r_head == r_slot) r_head <= rd_next;
                    if (r_tail == r_slot) r_tail <= r_prev;
                    if (r_ptr == r_slot)  r_ptr  <= rd_next;
                end
            end
            if (i_cmd.enable) begin
                r_en[r_slot] <= 1'b1;
            end
            if (i_cmd.dis_slot) begin
                r_en[r_slot] <= 1'b0;
            end
            if (i_cmd.dispatch) begin
                r_ptr <= rd_next;
            end
        end
    end

    // payload: tables, latched word, cursor, result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode      <= i_mode;
            r_slot      <= i_task_slot;
            r_period_in <= i_task_period;
            r_now       <= i_now_tick;
        end

        // one successor write per cycle
        if (i_cmd.add_tail) begin
            r_next[r_tail] <= r_slot;
        end else if (i_cmd.add_link) begin
            r_next[r_slot] <= r_empty ? r_slot : r_head;
        end else if (i_cmd.unlink && rd_next != r_slot) begin
            r_next[r_prev] <= rd_next;
        end

        if (i_cmd.add_link) begin
            r_period[r_slot] <= r_period_in;
        end

        if (i_cmd.add_link || i_cmd.enable) begin
            r_last[r_slot] <= r_now;
        end else if (i_cmd.dispatch) begin
            r_last[r_cur] <= r_now;
        end

        // cursor
        if (i_cmd.walk_init) begin
            r_cur  <= r_head;
            r_prev <= r_tail;
            r_cnt  <= '0;
        end else if (i_cmd.scan_init) begin
            r_cur <= r_ptr;
            r_cnt <= '0;
        end else if (i_cmd.walk_step || i_cmd.scan_step) begin
            r_prev <= r_cur;
            r_cur  <= rd_next;
            r_cnt  <= r_cnt + 1'b1;
        end

        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.res_status;
            r_out_disp   <= i_cmd.res_disp;
            r_out_task   <= i_cmd.res_disp ? r_cur : '0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_dispatched      = r_out_disp;
    assign o_dispatched_task = r_out_task;

endmodule

/* rtl/ptd_ctrl.sv */
// Controller of the periodic task dispatcher: sequences add, remove, enable,
// disable and run over the datapath. Depends on ptd_pkg.
module ptd_ctrl import ptd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_ADD_TAIL = 8'b0000_0100,
        S_ADD_LINK = 8'b0000_1000,
        S_WALK     = 8'b0001_0000,
        S_UNLINK   = 8'b0010_0000,
        S_SCAN     = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state  r_state, n_state;
    t_status r_res_status, n_res_status;
    logic    r_res_disp, n_res_disp;

    assign o_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_res_status = r_res_status;
        n_res_disp   = r_res_disp;
        o_cmd        = '0;
        o_cmd.res_status = r_res_status;
        o_cmd.res_disp   = r_res_disp;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_status = ST_OK;
                n_res_disp   = 1'b0;
                n_state      = S_DONE;
                unique case (i_stat.mode) inside
                    MODE_RUN: begin
                        if (!i_stat.ring_empty) begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    MODE_ADD: begin
                        if (i_stat.period_zero) begin
                            n_res_status = ST_BAD_PARAM;
                        end else if (i_stat.slot_linked) begin
                            n_res_status = ST_LINKED;
                        end else if (i_stat.ring_empty) begin
                            n_state = S_ADD_LINK;
                        end else begin
                            n_state = S_ADD_TAIL;
                        end
                    end
                    MODE_REMOVE, MODE_ENABLE, MODE_DISABLE: begin
                        if (i_stat.ring_empty || !i_stat.slot_linked) begin
                            n_res_status = ST_NOT_FOUND;
                        end else if (i_stat.mode == MODE_REMOVE) begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_WALK;
                        end else if (i_stat.mode == MODE_ENABLE) begin
                            o_cmd.enable = 1'b1;
                        end else begin
                            o_cmd.dis_slot = 1'b1;
                        end
                    end
                    default: begin
                        n_res_status = ST_BAD_PARAM;
                    end
                endcase
            end
            S_ADD_TAIL: begin
                o_cmd.add_tail = 1'b1;
                n_state        = S_ADD_LINK;
            end
            S_ADD_LINK: begin
                o_cmd.add_link = 1'b1;
                n_state        = S_DONE;
            end
            // find the predecessor of the named slot
            S_WALK: begin
                if (i_stat.cur_hit || i_stat.walk_last) begin
                    n_state = S_UNLINK;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_DONE;
            end
            // one ring entry per cycle from the round-robin pointer
            S_SCAN: begin
                if (i_stat.due) begin
                    o_cmd.dispatch = 1'b1;
                    n_res_disp     = 1'b1;
                    n_state        = S_DONE;
                end else if (i_stat.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_status <= ST_OK;
            r_res_disp   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_res_status <= n_res_status;
            r_res_disp   <= n_res_disp;
        end
    end

endmodule

/* rtl/periodic_task_dispatcher_core.sv */
// Periodic task dispatcher, top level. One word at a time.
// Each word is latched and decoded; add links the slot, behind the tail if any,
// remove walks to the predecessor and unlinks, run scans, then done loads the result.
// Walk and scan read one ring entry per cycle through the slot table port.
// A word is taken only while idle; the result register lets the next word in.
// Reset (synchronous, active low): ring empty, all marks clear, pointers zero.
module periodic_task_dispatcher_core import ptd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SLOT_W-1:0] i_task_slot,
    input  logic [TICK_W-1:0] i_task_period,
    input  logic [TICK_W-1:0] i_now_tick,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic              o_dispatched,
    output logic [SLOT_W-1:0] o_dispatched_task
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ptd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ptd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_mode            (i_mode),
        .i_task_slot       (i_task_slot),
        .i_task_period     (i_task_period),
        .i_now_tick        (i_now_tick),
        .i_stall           (i_stall),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_dispatched      (o_dispatched),
        .o_dispatched_task (o_dispatched_task)
    );

    // empty ring holds no linked slot
    a_empty_unlinked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.ring_empty |-> !stat.any_linked)
        else $error("ring empty while a slot is linked");

    // an accepted word keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted without going busy");

    // a dispatch always reports ok
    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dispatched) |-> (o_status == ST_OK))
        else $error("dispatch with non-ok status");

    // no dispatch means slot field zero
    a_no_dispatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_dispatched) |-> (o_dispatched_task == '0))
        else $error("task slot set without dispatch");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for periodic_task_dispatcher_core: scheduler predictor,
// queue-fed driver and result monitor with random idling on both sides.
// Depends on rtl/ptd_pkg.sv and rtl/periodic_task_dispatcher_core.sv.
module tb_top;
    import ptd_pkg::*;

    // one command word as offered to the block
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] tick;
        bit                drain;   // hold this word until all results are back
    } sched_op_t;

    // one result word as predicted
    typedef struct {
        t_status           status;
        logic              disp;
        logic [SLOT_W-1:0] slot_id;
    } sched_outcome_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [MODE_W-1:0] i_mode = '0;
    logic [SLOT_W-1:0] i_task_slot = '0;
    logic [TICK_W-1:0] i_task_period = '0;
    logic [TICK_W-1:0] i_now_tick = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_status;
    logic              o_dispatched;
    logic [SLOT_W-1:0] o_dispatched_task;

    sched_op_t      op_q[$];
    sched_outcome_t outcome_q[$];
    sched_op_t      cur_op;
    int             err_count = 0;
    int             tx_sent = 0;
    int             tx_gap = 0;
    int             rx_count = 0;
    int             rx_wait = 0;
    int             hold_left = 0;
    int             cycle_count = 0;

    // predictor copy of the scheduler state
    logic [SLOT_W-1:0] sched_next[MAX_TASKS];
    logic [TICK_W-1:0] sched_period[MAX_TASKS];
    logic [TICK_W-1:0] sched_stamp[MAX_TASKS];
    logic              sched_en[MAX_TASKS];
    logic              sched_linked[MAX_TASKS];
    logic [SLOT_W-1:0] sched_head = '0;
    logic [SLOT_W-1:0] sched_tail = '0;
    logic [SLOT_W-1:0] sched_rr = '0;
    logic              sched_empty = 1'b1;

    periodic_task_dispatcher_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_task_slot       (i_task_slot),
        .i_task_period     (i_task_period),
        .i_now_tick        (i_now_tick),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_dispatched      (o_dispatched),
        .o_dispatched_task (o_dispatched_task)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // idle cycles before the next word; every fourth stretch of 80 runs flat out
    function automatic int pick_gap(input int n);
        if ((n / 80) % 4 == 3)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    // splice a linked slot out of the ring
    task automatic unlink_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] succ;
        bit                hit;
        prev = sched_tail;
        cur  = sched_head;
        hit  = 0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (!hit) begin
                if (cur == s) begin
                    hit = 1;
                end else begin
                    prev = cur;
                    cur  = sched_next[cur];
                end
            end
        end
        succ = sched_next[s];
        if (succ == s) begin
            // last slot gone: ring back to its reset shape
            sched_empty = 1'b1;
            sched_head  = '0;
            sched_tail  = '0;
            sched_rr    = '0;
        end else begin
            sched_next[prev] = succ;
            if (sched_head == s) sched_head = succ;
            if (sched_tail == s) sched_tail = prev;
            if (sched_rr == s)   sched_rr   = succ;
        end
        sched_next[s]   = '0;
        sched_linked[s] = 1'b0;
        sched_en[s]     = 1'b0;
    endtask

    // apply one accepted word to the predictor and queue its outcome
    task automatic predict_op(input sched_op_t op);
        sched_outcome_t    res;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] start;
        logic [TICK_W-1:0] elapsed;
        bit                done;
        res.status  = ST_OK;
        res.disp    = 1'b0;
        res.slot_id = '0;
        if (op.mode == MODE_RUN) begin
            // one lap from the round-robin pointer, first due slot wins
            if (!sched_empty) begin
                start = sched_rr;
                cur   = start;
                done  = 0;
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (!done) begin
                        elapsed = op.tick - sched_stamp[cur];
                        if (sched_linked[cur] && sched_en[cur] &&
                            elapsed >= sched_period[cur]) begin
                            sched_rr         = sched_next[cur];
                            sched_stamp[cur] = op.tick;
                            res.disp         = 1'b1;
                            res.slot_id      = cur;
                            done             = 1;
                        end else begin
                            cur = sched_next[cur];
                            if (cur == start) done = 1;
                        end
                    end
                end
            end
        end else if (op.mode > MODE_RUN) begin
            res.status = ST_BAD_PARAM;
        end else if (op.mode == MODE_ADD) begin
            if (op.period == '0) begin
                res.status = ST_BAD_PARAM;
            end else if (sched_linked[op.slot]) begin
                res.status = ST_LINKED;
            end else begin
                sched_period[op.slot] = op.period;
                sched_stamp[op.slot]  = op.tick;
                sched_en[op.slot]     = 1'b1;
                sched_linked[op.slot] = 1'b1;
                if (sched_empty) begin
                    sched_next[op.slot] = op.slot;
                    sched_head          = op.slot;
                    sched_tail          = op.slot;
                    sched_rr            = op.slot;
                    sched_empty         = 1'b0;
                end else begin
                    sched_next[op.slot]    = sched_head;
                    sched_next[sched_tail] = op.slot;
                    sched_tail             = op.slot;
                end
            end
        end else if (sched_empty || !sched_linked[op.slot]) begin
            res.status = ST_NOT_FOUND;
        end else if (op.mode == MODE_REMOVE) begin
            unlink_slot(op.slot);
        end else if (op.mode == MODE_ENABLE) begin
            sched_stamp[op.slot] = op.tick;
            sched_en[op.slot]    = 1'b1;
        end else begin
            sched_en[op.slot] = 1'b0;
        end
        outcome_q.push_back(res);
    endtask

    task automatic queue_op(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                            input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] tick,
                            input bit drain);
        sched_op_t op;
        op.mode   = mode;
        op.slot   = slot;
        op.period = period;
        op.tick   = tick;
        op.drain  = drain;
        op_q.push_back(op);
    endtask

    // driver: present words from op_q, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_op(cur_op);
                tx_sent++;
                tx_gap = pick_gap(tx_sent);
            end
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (op_q.size() != 0 &&
                             !(op_q[0].drain && outcome_q.size() != 0)) begin
                    cur_op = op_q.pop_front();
                    i_mode        <= cur_op.mode;
                    i_task_slot   <= cur_op.slot;
                    i_task_period <= cur_op.period;
                    i_now_tick    <= cur_op.tick;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-offs so the block backs up into its input
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (cycle_count == 3000 || cycle_count == 25000)
                hold_left <= 300;
        end
    end

    // monitor: check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        sched_outcome_t exp_res;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (outcome_q.size() == 0) begin
                    flag_mismatch("result word with nothing expected");
                end else begin
                    exp_res = outcome_q.pop_front();
                    if (o_status != exp_res.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                o_status, exp_res.status));
                    if (o_dispatched != exp_res.disp)
                        flag_mismatch($sformatf("dispatched %0b, expected %0b",
                                                o_dispatched, exp_res.disp));
                    if (o_dispatched_task != exp_res.slot_id)
                        flag_mismatch($sformatf("dispatched_task %0d, expected %0d",
                                                o_dispatched_task, exp_res.slot_id));
                end
                rx_count++;
                rx_wait = pick_gap(rx_count);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_stall <= (rx_wait != 0) || (hold_left != 0);
        end
    end

    initial begin
        int r;
        int spin;
        logic [MODE_W-1:0] mode;
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] tick_now;

        for (int i = 0; i < MAX_TASKS; i++) begin
            sched_next[i]   = '0;
            sched_period[i] = '0;
            sched_stamp[i]  = '0;
            sched_en[i]     = 1'b0;
            sched_linked[i] = 1'b0;
        end

        // directed: empty ring, error codes, tick and period extremes, unlink paths
        queue_op(MODE_RUN,     4'd0,  32'd0,         32'd0,         0);
        queue_op(MODE_REMOVE,  4'd3,  32'd0,         32'd0,         0);
        queue_op(MODE_ENABLE,  4'd3,  32'd0,         32'd0,         0);
        queue_op(MODE_DISABLE, 4'd3,  32'd0,         32'd0,         0);
        queue_op(MODE_ADD,     4'd0,  32'd0,         32'd0,         0);
        queue_op(MODE_ADD,     4'd0,  32'hFFFF_FFFF, 32'd0,         0);
        queue_op(MODE_ADD,     4'd0,  32'd5,         32'd1,         0);
        // zero period wins over the already-linked check
        queue_op(MODE_ADD,     4'd0,  32'd0,         32'd1,         0);
        queue_op(MODE_ADD,     4'd15, 32'd1,         32'hFFFF_FFFF, 0);
        queue_op(MODE_ADD,     4'd7,  32'd100,       32'd10,        0);
        queue_op(MODE_RUN,     4'd0,  32'd0,         32'd0,         0);
        queue_op(MODE_RUN,     4'd9,  32'd0,         32'hFFFF_FFFF, 0);
        queue_op(3'd5,         4'd0,  32'd7,         32'd0,         0);
        queue_op(3'd6,         4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        queue_op(3'd7,         4'd7,  32'd0,         32'd3,         0);
        queue_op(MODE_DISABLE, 4'd15, 32'd0,         32'd150,       0);
        queue_op(MODE_RUN,     4'd0,  32'd0,         32'd200,       0);
        queue_op(MODE_ENABLE,  4'd15, 32'd0,         32'd300,       0);
        queue_op(MODE_RUN,     4'd0,  32'd0,         32'd301,       0);
        queue_op(MODE_REMOVE,  4'd7,  32'd0,         32'd302,       0);
        queue_op(MODE_REMOVE,  4'd0,  32'd0,         32'd303,       0);
        queue_op(MODE_REMOVE,  4'd0,  32'd0,         32'd304,       0);
        queue_op(MODE_RUN,     4'd0,  32'd0,         32'd400,       0);
        queue_op(MODE_REMOVE,  4'd15, 32'd0,         32'd401,       0);
        queue_op(MODE_RUN,     4'd0,  32'd0,         32'd500,       0);

        // random: mostly ring traffic and runs on a slowly advancing tick
        tick_now = $urandom;
        for (int i = 0; i < 1450; i++) begin
            r = $urandom_range(0, 99);
            if (r < 24)      mode = MODE_ADD;
            else if (r < 34) mode = MODE_REMOVE;
            else if (r < 44) mode = MODE_ENABLE;
            else if (r < 54) mode = MODE_DISABLE;
            else if (r < 96) mode = MODE_RUN;
            else             mode = 3'($urandom_range(5, 7));
            r = $urandom_range(0, 99);
            if (r < 3)       period = '0;
            else if (r < 10) period = $urandom;
            else if (r < 20) period = $urandom_range(1, 1000);
            else             period = $urandom_range(1, 40);
            if ($urandom_range(0, 99) < 4)
                tick_now = $urandom;
            else
                tick_now = tick_now + $urandom_range(0, 12);
            queue_op(mode, 4'($urandom_range(0, 15)), period, tick_now,
                     (i == 0 || i == 400 || i == 1000));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything offered and taken
        do begin
            @(posedge i_clk);
            #1;
        end while (op_q.size() != 0 || i_valid);

        spin = 0;
        while (outcome_q.size() != 0 && spin < 3000) begin
            @(posedge i_clk);
            spin++;
        end
        if (outcome_q.size() != 0)
            flag_mismatch($sformatf("%0d expected results never came", outcome_q.size()));

        // let any stray result show up
        repeat (40) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
